/* rtl/whc_pkg.sv */
// shared types, codes and constants of the windowed health watchdog
package whc_pkg;

	// default build values
	localparam int DEF_WINDOW_DEPTH = 64;
	localparam int DEF_TIME_BITS    = 32;

	// fixed field widths of the stream and configuration ports
	localparam int ACTION_W    = 2;
	localparam int NOW_W       = 32;
	localparam int LOOKBACK_W  = 32;
	localparam int THRESH_W    = 16;
	localparam int COUNT_OUT_W = 7;
	localparam int SUM_OUT_W   = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 24;

	// 1.0 in Q2.14 is a left shift by this many bits
	localparam int ONE_Q_SHIFT = 14;

	// register reset values
	localparam logic [LOOKBACK_W-1:0] LOOKBACK_RST = 32'd1000;

	// input action codes
	typedef enum logic [ACTION_W-1:0] {
		ACT_PET   = 2'd0,
		ACT_KICK  = 2'd1,
		ACT_CHECK = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOOKBACK  = 2'd0,
		CFG_THRESHOLD = 2'd1,
		CFG_ENABLE    = 2'd2
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_PURGE,
		ST_MUL,
		ST_DONE
	} state_t;

	// per-cell control: take the neighbor's entry or load a new one
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

	// event value of a stored sign bit: good is +1, bad is -1
	function automatic logic signed [1:0] sign_step(input logic bad);
		sign_step = bad ? -2'sd1 : 2'sd1;
	endfunction

endpackage

/* rtl/whc_cell.sv */
// one window cell: holds a time stamp and a sign, shifts toward the oldest end
module whc_cell #(
	parameter int STAMP_W = whc_pkg::DEF_TIME_BITS
) (
	input  logic                clk,
	input  whc_pkg::cell_ctrl_t ctrl,
	input  logic [STAMP_W-1:0]  new_stamp,
	input  logic                new_bad,
	input  logic [STAMP_W-1:0]  next_stamp,
	input  logic                next_bad,
	output logic [STAMP_W-1:0]  stamp,
	output logic                bad
);
	import whc_pkg::*;

	logic [STAMP_W-1:0] stamp_q;
	logic               bad_q;

	// load wins over shift; payload needs no reset
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			stamp_q <= new_stamp;
			bad_q   <= new_bad;
		end else if (ctrl.shift) begin
			stamp_q <= next_stamp;
			bad_q   <= next_bad;
		end
	end

	assign stamp = stamp_q;
	assign bad   = bad_q;

endmodule

/* rtl/windowed_health_watchdog.sv */
// top level: sequencer, counters, chain of window cells and output register
//
// channel  dir  transfer when          payload
// s_*      in   s_tvalid & s_tready    action, now_time
// m_*      out  m_tvalid & m_tready    fail, health_ok, entry_count, health_sum, overflow
// cfg_*    in   cfg_valid & cfg_ready  cfg_index, cfg_data (always ready)
//
// a pet or enabled kick steps through accept, cell write, multiply and result; a
// disabled kick or a no-op skips the cell write; a check purges in place of the
// cell write, dropping one expired entry from the head cell per purge step.
// the next item is taken once the previous one has reached the output
// register; the result waits there while m_tready is low, and a second
// finished result waits in the sequencer until the register frees.
// reset clears state, counters, config registers and m_tvalid; cells and data registers are not reset.
module windowed_health_watchdog #(
	parameter int WINDOW_DEPTH = whc_pkg::DEF_WINDOW_DEPTH,
	parameter int TIME_BITS    = whc_pkg::DEF_TIME_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// stream in
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [1:0] action, [33:2] now_time, [39:34] zero
	input  logic [whc_pkg::S_TDATA_W-1:0]       s_tdata,
	// stream out
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [0] fail, [1] health_ok, [8:2] entry_count, [16:9] health_sum,
	// [17] overflow, [23:18] zero
	output logic [whc_pkg::M_TDATA_W-1:0]       m_tdata,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [whc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [whc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import whc_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int CMP_W = CNT_W + 18;
	localparam int AGE_W = (TIME_BITS > LOOKBACK_W) ? TIME_BITS : LOOKBACK_W;

	// configuration registers
	logic [LOOKBACK_W-1:0]      lookback_q;
	logic signed [THRESH_W-1:0] thr_q;
	logic                       en_q;

	// sequencer and window counters
	state_t                     state_q, state_d;
	action_t                    act_q;
	logic [TIME_BITS-1:0]       now_q;
	logic                       ovf_q, ovf_d;
	logic [CNT_W-1:0]           cnt_q, cnt_d;
	logic signed [SUM_W-1:0]    sum_q, sum_d;
	logic signed [CMP_W-1:0]    rhs_q;
	logic                       shift_all, add_we, load_out;

	// output register
	logic                       m_tvalid_q;
	logic                       fail_q, ok_q, oflag_q;
	logic [COUNT_OUT_W-1:0]     ocnt_q;
	logic [SUM_OUT_W-1:0]       osum_q;

	// cell chain
	logic [TIME_BITS-1:0]       cell_stamp [WINDOW_DEPTH];
	logic                       cell_bad   [WINDOW_DEPTH];
	cell_ctrl_t                 cell_ctrl  [WINDOW_DEPTH];

	logic                       full, new_bad, expired;
	logic [CNT_W-1:0]           wpos;
	logic [TIME_BITS-1:0]       age;
	logic signed [CMP_W-1:0]    lhs;
	logic                       nonempty, fail_c, ok_c;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookback_q <= LOOKBACK_RST;
			thr_q      <= '0;
			en_q       <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LOOKBACK:  lookback_q <= cfg_data[LOOKBACK_W-1:0];
				CFG_THRESHOLD: thr_q      <= cfg_data[THRESH_W-1:0];
				CFG_ENABLE:    en_q       <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	// window status
	assign full    = (cnt_q == CNT_W'(WINDOW_DEPTH));
	assign new_bad = (act_q == ACT_KICK);
	assign wpos    = full ? CNT_W'(WINDOW_DEPTH - 1) : cnt_q;
	assign age     = now_q - cell_stamp[0];
	assign expired = (AGE_W'(age) > AGE_W'(lookback_q));

	// next state and control
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		sum_d     = sum_q;
		ovf_d     = ovf_q;
		shift_all = 1'b0;
		add_we    = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					ovf_d = 1'b0;
					case (action_t'(s_tdata[ACTION_W-1:0]))
						ACT_PET:   state_d = ST_ADD;
						ACT_KICK:  state_d = en_q ? ST_ADD : ST_MUL;
						ACT_CHECK: state_d = ST_PURGE;
						default:   state_d = ST_MUL;
					endcase
				end
			end
			ST_ADD: begin
				add_we = 1'b1;
				if (full) begin
					shift_all = 1'b1;
					ovf_d     = 1'b1;
					sum_d     = sum_q - SUM_W'(sign_step(cell_bad[0]))
						+ SUM_W'(sign_step(new_bad));
				end else begin
					cnt_d = cnt_q + 1'b1;
					sum_d = sum_q + SUM_W'(sign_step(new_bad));
				end
				state_d = ST_MUL;
			end
			ST_PURGE: begin
				if (cnt_q != '0 && expired) begin
					shift_all = 1'b1;
					cnt_d     = cnt_q - 1'b1;
					sum_d     = sum_q - SUM_W'(sign_step(cell_bad[0]));
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
			ovf_q   <= ovf_d;
		end
	end

	// item capture and threshold product
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_q <= action_t'(s_tdata[ACTION_W-1:0]);
			now_q <= TIME_BITS'(s_tdata[ACTION_W +: NOW_W]);
		end
		rhs_q <= CMP_W'(thr_q) * CMP_W'($signed({1'b0, cnt_q}));
	end

	// mean compare: sum * 1.0 against threshold * count
	assign lhs      = CMP_W'(sum_q) <<< ONE_Q_SHIFT;
	assign nonempty = (cnt_q != '0);
	assign ok_c     = nonempty && (lhs > rhs_q);
	assign fail_c   = nonempty && en_q && (act_q == ACT_CHECK) && (lhs < rhs_q);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			fail_q  <= fail_c;
			ok_q    <= ok_c;
			ocnt_q  <= COUNT_OUT_W'(cnt_q);
			osum_q  <= SUM_OUT_W'(sum_q);
			oflag_q <= ovf_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(M_TDATA_W - 18)'(0), oflag_q, osum_q, ocnt_q, ok_q, fail_q};

	// chain of cells, index 0 holds the oldest entry
	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		logic [TIME_BITS-1:0] nb_stamp;
		logic                 nb_bad;

		if (i == WINDOW_DEPTH - 1) begin : g_last
			assign nb_stamp = cell_stamp[i];
			assign nb_bad   = cell_bad[i];
		end else begin : g_mid
			assign nb_stamp = cell_stamp[i+1];
			assign nb_bad   = cell_bad[i+1];
		end

		assign cell_ctrl[i].shift = shift_all;
		assign cell_ctrl[i].load  = add_we && (wpos == CNT_W'(i));

		whc_cell #(
			.STAMP_W (TIME_BITS)
		) u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl[i]),
			.new_stamp  (now_q),
			.new_bad    (new_bad),
			.next_stamp (nb_stamp),
			.next_bad   (nb_bad),
			.stamp      (cell_stamp[i]),
			.bad        (cell_bad[i])
		);
	end

	// window never holds more entries than cells
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(WINDOW_DEPTH))
		else $error("window count above depth");

	// sum magnitude never exceeds the entry count
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(sum_q <= $signed({1'b0, cnt_q})) && (-sum_q <= $signed({1'b0, cnt_q})))
		else $error("window sum out of range of count");

	// each purge step drops exactly one entry
	a_purge_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PURGE && shift_all) |=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("purge step did not drop one entry");

	// a finished result waits while the output register is held
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && m_tvalid_q && !m_tready) |=> (state_q == ST_DONE))
		else $error("result overwrote a pending output");

endmodule

/* tb/tb.sv */
// self-checking testbench of the windowed health watchdog with a built-in window predictor
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import whc_pkg::*;

	localparam int          WINDOW_SLOTS = DEF_WINDOW_DEPTH;
	localparam int          CYCLE_LIMIT  = 1000000;
	localparam int          RX_HOLD      = 300;
	localparam int          PHASE_SETTLE = 4;
	localparam int          END_SETTLE   = 100;
	// no register sits at this index, writes to it must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic                   fail;
		logic                   health_ok;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic [SUM_OUT_W-1:0]   health_sum;
		logic                   overflow;
	} health_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predicted register file
	logic [LOOKBACK_W-1:0] cfg_lookback  = LOOKBACK_RST;
	logic [THRESH_W-1:0]   cfg_threshold = '0;
	logic                  cfg_enable    = 1'b0;

	// predicted event window, oldest entry at win_head
	logic [NOW_W-1:0]      win_stamp [WINDOW_SLOTS];
	logic                  win_bad   [WINDOW_SLOTS];
	int                    win_head  = 0;
	int                    win_count = 0;
	int                    win_sum   = 0;

	health_result_t        pending_health[$];

	// stimulus shaping and run bookkeeping
	bit                    tx_idling;
	logic                  rx_idling;
	logic                  rx_hold_req;
	int                    mismatches    = 0;
	int                    items_sent    = 0;
	int                    results_seen  = 0;
	int                    reg_writes    = 0;
	int                    overflow_seen = 0;
	int                    fail_seen     = 0;
	int                    ok_seen       = 0;
	int                    cycle_count   = 0;

	windowed_health_watchdog u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		// [1:0] action, [33:2] now_time, [39:34] zero
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		// [0] fail, [1] health_ok, [8:2] entry_count, [16:9] health_sum, [17] overflow
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic void window_drop_oldest();
		win_sum  -= win_bad[win_head] ? -1 : 1;
		win_head  = (win_head + 1) % WINDOW_SLOTS;
		win_count--;
	endfunction

	// append an event, evicting the oldest one when the window is full
	function automatic logic window_add(logic [NOW_W-1:0] stamp, logic bad);
		logic dropped;
		int   slot;
		dropped = 1'b0;
		if (win_count >= WINDOW_SLOTS) begin
			window_drop_oldest();
			dropped = 1'b1;
		end
		slot            = (win_head + win_count) % WINDOW_SLOTS;
		win_stamp[slot] = stamp;
		win_bad[slot]   = bad;
		win_count++;
		win_sum += bad ? -1 : 1;
		return dropped;
	endfunction

	function automatic health_result_t predict_watchdog(action_t act, logic [NOW_W-1:0] stamp);
		health_result_t r;
		logic [NOW_W-1:0] age;
		longint            lhs;
		longint            rhs;
		bit                purging;
		r = '0;
		case (act)
			ACT_PET: r.overflow = window_add(stamp, 1'b0);
			ACT_KICK: begin
				if (cfg_enable)
					r.overflow = window_add(stamp, 1'b1);
			end
			ACT_CHECK: begin
				// drop from the oldest end until the first live entry
				purging = 1'b1;
				while (purging && win_count > 0) begin
					age = stamp - win_stamp[win_head];
					if (age > cfg_lookback)
						window_drop_oldest();
					else
						purging = 1'b0;
				end
			end
			default: ;
		endcase
		// mean against threshold as exact integer products
		lhs = longint'(win_sum) * (longint'(1) << ONE_Q_SHIFT);
		rhs = longint'($signed(cfg_threshold)) * longint'(win_count);
		if (win_count > 0) begin
			r.health_ok = lhs > rhs;
			r.fail      = (act == ACT_CHECK) && cfg_enable && (lhs < rhs);
		end
		r.entry_count = win_count[COUNT_OUT_W-1:0];
		r.health_sum  = win_sum[SUM_OUT_W-1:0];
		return r;
	endfunction

	// ---------------------------------------------------------------- drivers

	task automatic send_item(action_t act, logic [NOW_W-1:0] stamp);
		health_result_t want;
		if (tx_idling && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W-NOW_W-ACTION_W){1'b0}}, stamp, act};
		do @(posedge clk); while (!s_tready);
		want = predict_watchdog(act, stamp);
		pending_health = {pending_health, want};
		items_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_LOOKBACK:  cfg_lookback  = value[LOOKBACK_W-1:0];
			CFG_THRESHOLD: cfg_threshold = value[THRESH_W-1:0];
			CFG_ENABLE:    cfg_enable    = value[0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// stop offering items and wait until every predicted result has come back
	task automatic wait_results_done(int settle);
		s_tvalid <= 1'b0;
		while (pending_health.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	function automatic action_t pick_action(int pet_pct, int kick_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			return ACT_NOP;
		if (roll < 3 + pet_pct)
			return ACT_PET;
		if (roll < 3 + pet_pct + kick_pct)
			return ACT_KICK;
		return ACT_CHECK;
	endfunction

	// ---------------------------------------------------------------- result sink

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				// long hold-off so the block backs up into its input
				rx_hold_req <= 1'b0;
				m_tready    <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
				m_tready    <= 1'b1;
			end else if (rx_idling && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin : result_check
		health_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			overflow_seen += m_tdata[17];
			fail_seen     += m_tdata[0];
			ok_seen       += m_tdata[1];
			if (pending_health.size() == 0) begin
				$error("result transfer with no prediction pending");
				mismatches++;
			end else begin
				want = pending_health.pop_front();
				compare_field("fail", want.fail, m_tdata[0]);
				compare_field("health_ok", want.health_ok, m_tdata[1]);
				compare_field("entry_count", want.entry_count, m_tdata[8:2]);
				compare_field("health_sum", $signed(want.health_sum), $signed(m_tdata[16:9]));
				compare_field("overflow", want.overflow, m_tdata[17]);
				compare_field("pad", 0, m_tdata[M_TDATA_W-1:18]);
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// reset settings: watchdog off, lookback 1000, threshold 0
	task automatic test_disabled_window();
		send_item(ACT_CHECK, 32'd0);
		send_item(ACT_NOP, 32'd0);
		send_item(ACT_KICK, 32'd5);
		send_item(ACT_PET, 32'd10);
		send_item(ACT_CHECK, 32'd1010);
		send_item(ACT_CHECK, 32'd1011);
		wait_results_done(PHASE_SETTLE);
	endtask

	// threshold extremes, out-of-range threshold and a disabled check
	task automatic test_enabled_threshold();
		write_reg(CFG_LOOKBACK, 32'hFFFF_FFFF);
		write_reg(CFG_THRESHOLD, 32'h0000_4000);
		write_reg(CFG_ENABLE, 32'h0000_0001);
		send_item(ACT_PET, 32'd100);
		send_item(ACT_KICK, 32'd100);
		send_item(ACT_CHECK, 32'd200);
		wait_results_done(PHASE_SETTLE);
		write_reg(CFG_THRESHOLD, 32'h0000_C000);
		send_item(ACT_CHECK, 32'd200);
		wait_results_done(PHASE_SETTLE);
		write_reg(CFG_THRESHOLD, 32'h0000_0000);
		send_item(ACT_CHECK, 32'd250);
		wait_results_done(PHASE_SETTLE);
		write_reg(CFG_THRESHOLD, 32'hABCD_8000);
		send_item(ACT_KICK, 32'd300);
		wait_results_done(PHASE_SETTLE);
		write_reg(CFG_THRESHOLD, 32'h0000_7FFF);
		write_reg(CFG_ENABLE, 32'hFFFF_FFFE);
		send_item(ACT_CHECK, 32'd300);
		wait_results_done(PHASE_SETTLE);
	endtask

	// zero lookback, stamps across the time wrap and stamps ahead of now
	task automatic test_purge_edges();
		write_reg(CFG_LOOKBACK, 32'd0);
		write_reg(CFG_THRESHOLD, 32'd0);
		write_reg(CFG_ENABLE, 32'd1);
		write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
		send_item(ACT_CHECK, 32'd300);
		send_item(ACT_PET, 32'd300);
		send_item(ACT_CHECK, 32'd301);
		wait_results_done(PHASE_SETTLE);
		write_reg(CFG_LOOKBACK, 32'd16);
		send_item(ACT_PET, 32'hFFFF_FFF8);
		send_item(ACT_CHECK, 32'h0000_0004);
		send_item(ACT_CHECK, 32'h0000_0010);
		send_item(ACT_PET, 32'd500);
		send_item(ACT_CHECK, 32'd400);
		wait_results_done(PHASE_SETTLE);
	endtask

	// fill with bad events past full, then flush with good ones
	task automatic test_window_overflow();
		logic [NOW_W-1:0] stamp;
		write_reg(CFG_LOOKBACK, 32'hFFFF_FFFF);
		write_reg(CFG_ENABLE, 32'd1);
		stamp = 32'd1000;
		for (int i = 0; i < WINDOW_SLOTS + 2; i++) begin
			stamp += $urandom_range(0, 3);
			send_item(ACT_KICK, stamp);
		end
		send_item(ACT_CHECK, stamp);
		for (int i = 0; i < WINDOW_SLOTS + 2; i++) begin
			stamp += $urandom_range(0, 3);
			send_item(ACT_PET, stamp);
		end
		send_item(ACT_CHECK, stamp);
		wait_results_done(PHASE_SETTLE);
	endtask

	// random event streams under a series of register settings
	task automatic test_random_phases(int phases, int per_phase);
		logic [NOW_W-1:0]      stamp;
		logic [NOW_W-1:0]      span;
		logic [LOOKBACK_W-1:0] lookback;
		logic [THRESH_W-1:0]   thr;
		logic [31:0]           upper;
		int                    pet_pct;
		int                    kick_pct;
		int                    roll;
		for (int p = 0; p < phases; p++) begin
			case (p < 6 ? p : $urandom_range(0, 5))
				0:       lookback = 32'd0;
				1:       lookback = 32'hFFFF_FFFF;
				2:       lookback = $urandom_range(1, 8);
				3:       lookback = $urandom_range(10, 200);
				4:       lookback = $urandom_range(1000, 100000);
				default: lookback = $urandom;
			endcase
			case (p < 5 ? p : $urandom_range(0, 4))
				0:       thr = 16'h4000;
				1:       thr = 16'hC000;
				2:       thr = 16'h0000;
				3:       thr = THRESH_W'($urandom);
				default: thr = THRESH_W'($urandom_range(0, 32768) - 16384);
			endcase
			write_reg(CFG_LOOKBACK, lookback);
			upper = $urandom;
			write_reg(CFG_THRESHOLD, {upper[31:16], thr});
			upper = $urandom;
			write_reg(CFG_ENABLE, {upper[31:1], (p % 4 != 3)});
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_UNUSED, $urandom);

			pet_pct  = $urandom_range(20, 60);
			kick_pct = $urandom_range(10, 90 - pet_pct);
			span     = (cfg_lookback > 32'd4096) ? 32'd300 : cfg_lookback / 8 + 1;
			stamp    = $urandom;
			for (int i = 0; i < per_phase; i++) begin
				roll = $urandom_range(0, 49);
				// mostly forward steps, with rare jumps back and far ahead
				if (roll == 0)
					stamp = stamp - $urandom_range(1, 50);
				else if (roll == 1)
					stamp = stamp + $urandom;
				else
					stamp = stamp + $urandom_range(0, span);
				send_item(pick_action(pet_pct, kick_pct), stamp);
			end
			wait_results_done(PHASE_SETTLE);
		end
	endtask

	// input keeps offering while the output is held off
	task automatic test_output_backpressure();
		logic [NOW_W-1:0] stamp;
		write_reg(CFG_LOOKBACK, 32'd40);
		write_reg(CFG_ENABLE, 32'd1);
		tx_idling   = 1'b0;
		rx_hold_req <= 1'b1;
		stamp = $urandom;
		for (int i = 0; i < 24; i++) begin
			stamp += $urandom_range(0, 8);
			send_item(pick_action(40, 30), stamp);
		end
		wait_results_done(PHASE_SETTLE);
		tx_idling = 1'b1;
	endtask

	// full-rate stream with no gaps on either side
	task automatic test_streaming_no_idle(int count);
		logic [NOW_W-1:0] stamp;
		logic [31:0]      thr;
		tx_idling = 1'b0;
		rx_idling <= 1'b0;
		thr = $urandom_range(0, 32768) - 16384;
		write_reg(CFG_LOOKBACK, 32'd50);
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_ENABLE, 32'd1);
		stamp = $urandom;
		for (int i = 0; i < count; i++) begin
			stamp += $urandom_range(0, 6);
			send_item(pick_action(35, 30), stamp);
		end
		wait_results_done(END_SETTLE);
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= CFG_LOOKBACK;
		cfg_data    <= '0;
		rx_idling   <= 1'b1;
		rx_hold_req <= 1'b0;
		tx_idling    = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disabled_window();
		test_enabled_threshold();
		test_purge_edges();
		test_window_overflow();
		test_random_phases(12, 105);
		test_output_backpressure();
		test_streaming_no_idle(200);

		$display("covered %0d items and %0d results across %0d register writes",
			items_sent, results_seen, reg_writes);
		$display("results showed %0d overflow drops, %0d failed checks, %0d healthy windows",
			overflow_seen, fail_seen, ok_seen);
		if (mismatches == 0 && pending_health.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/whc_pkg.sv
rtl/whc_cell.sv
rtl/windowed_health_watchdog.sv
tb/tb.sv
